[hdl/sist_pkg.sv]
// Shared types and constants of the sorted interval set table.
package sist_pkg;

    localparam int TIME_BITS = 32;
    localparam int TOL_BITS  = 16;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADARG = 2'd2;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic [TIME_BITS-1:0] start_time;
        logic [TIME_BITS-1:0] end_time;
        logic [TIME_BITS-1:0] query_time;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           status;
        logic                 contained;
        logic [3:0]           containing_index;
        logic [TIME_BITS-1:0] current_end;
        logic                 has_next;
        logic [TIME_BITS-1:0] next_start;
        logic [4:0]           interval_count;
    } t_out_item;

    // Flags of the shared compare unit.
    typedef struct packed {
        logic a_lt;
        logic a_eq;
        logic a_gap_ok;
        logic b_lt;
    } t_cmp_res;

endpackage

[hdl/sist_ram.sv]
// Generic single write port RAM with registered read.
module sist_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/sist_cmp_unit.sv]
// Shared compare unit: one ordered compare with gap check and one less-than.
module sist_cmp_unit
    import sist_pkg::*;
(
    input  logic [TIME_BITS-1:0] i_x,
    input  logic [TIME_BITS-1:0] i_y,
    input  logic [TIME_BITS-1:0] i_u,
    input  logic [TIME_BITS-1:0] i_v,
    input  logic [TOL_BITS-1:0]  i_tol,
    output t_cmp_res             o_res
);

    logic [TIME_BITS-1:0] diff;

    // The gap flag is only meaningful when x lies above y.
    assign diff           = i_x - i_y;
    assign o_res.a_lt     = i_x < i_y;
    assign o_res.a_eq     = i_x == i_y;
    assign o_res.a_gap_ok = diff <= TIME_BITS'(i_tol);
    assign o_res.b_lt     = i_u < i_v;

endmodule

[hdl/sorted_interval_set_table.sv]
// Top level of the sorted interval set table: sequencer, table banks and result register.
//
// The block holds up to MAX_INTERVALS disjoint intervals sorted by start.
// Input items arrive on i_in_valid / o_in_stall / i_in_item and are taken
// when valid is high and stall is low. Mode add inserts [start,end] and
// merges neighbours whose gap does not exceed the merge tolerance; mode
// query looks up one time. Every item gives exactly one result item on
// o_out_valid / i_out_stall / o_out_item.
// An add walks the table through one RAM read port and one shared compare
// unit into the other bank. The next item can be taken in the cycle after
// the result is loaded. The input side stalls while an item is in work.
// A finished result sits in the output register; the next item is taken
// while it waits, and the block holds its own finished result until the
// output register frees up. The user writes the tolerance register through
// i_cfg_we / i_cfg_data only while idle; the block does not enforce this.
// Reset empties the table (the count goes to zero, no clearing pass) and
// clears the tolerance; the table memories themselves are not cleared.
module sorted_interval_set_table
    import sist_pkg::*;
#(
    parameter int MAX_INTERVALS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_item,
    input  logic                i_cfg_we,
    input  logic [TOL_BITS-1:0] i_cfg_data
);

    localparam int IW = $clog2(MAX_INTERVALS);
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int NW = $clog2(MAX_INTERVALS + 2);
    localparam int DW = 2 * TIME_BITS;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_FETCH  = 8'b0000_0010,
        S_LOAD   = 8'b0000_0100,
        S_MERGE  = 8'b0000_1000,
        S_FLUSH  = 8'b0001_0000,
        S_QFETCH = 8'b0010_0000,
        S_QLOAD  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic                 r_bank, n_bank;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_i, n_i;
    logic [NW-1:0]        r_n, n_n;
    logic                 r_have_last, n_have_last;
    logic                 r_placed, n_placed;
    logic [TIME_BITS-1:0] r_last_s, n_last_s;
    logic [TIME_BITS-1:0] r_last_e, n_last_e;
    logic [TIME_BITS-1:0] r_c_s, n_c_s;
    logic [TIME_BITS-1:0] r_c_e, n_c_e;
    logic [TIME_BITS-1:0] r_s, n_s;
    logic [TIME_BITS-1:0] r_e, n_e;
    logic [TIME_BITS-1:0] r_t, n_t;
    logic [TOL_BITS-1:0]  r_tol;
    logic [1:0]           r_status, n_status;
    logic                 r_contained, n_contained;
    logic [IW-1:0]        r_cidx, n_cidx;
    logic [TIME_BITS-1:0] r_cend, n_cend;
    logic                 r_has_next, n_has_next;
    logic [TIME_BITS-1:0] r_nstart, n_nstart;
    t_out_item            r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    logic                 in_accept;
    logic                 out_accept;
    logic                 can_load;
    logic                 joins;
    logic                 wr_en;
    logic [NW-1:0]        wr_idx_full;
    logic [DW-1:0]        wr_data;
    logic [DW-1:0]        rd0, rd1, rd;
    logic [TIME_BITS-1:0] rd_s, rd_e;
    logic [TIME_BITS-1:0] op_x, op_y, op_u, op_v;
    t_cmp_res             cmp;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_accept  = r_out_valid && !i_out_stall;
    assign can_load    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Two banks: the walk reads the active one and builds the merged table
    // in the other, which becomes active only when the add succeeds.
    assign wr_idx_full = r_n - NW'(1);
    assign wr_data     = {r_last_s, r_last_e};
    assign rd          = r_bank ? rd1 : rd0;
    assign rd_s        = rd[DW-1:TIME_BITS];
    assign rd_e        = rd[TIME_BITS-1:0];

    sist_ram #(.WIDTH(DW), .DEPTH(MAX_INTERVALS)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (wr_en && r_bank),
        .i_waddr (wr_idx_full[IW-1:0]),
        .i_wdata (wr_data),
        .i_raddr (r_i[IW-1:0]),
        .o_rdata (rd0)
    );

    sist_ram #(.WIDTH(DW), .DEPTH(MAX_INTERVALS)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (wr_en && !r_bank),
        .i_waddr (wr_idx_full[IW-1:0]),
        .i_wdata (wr_data),
        .i_raddr (r_i[IW-1:0]),
        .o_rdata (rd1)
    );

    // Operand selection for the shared compare unit, by sequencer state.
    always_comb begin
        op_x = r_c_s;
        op_y = r_last_e;
        op_u = r_last_e;
        op_v = r_c_e;
        unique case (r_state)
            S_IDLE: begin
                op_x = i_in_item.end_time;
                op_y = i_in_item.start_time;
            end
            S_LOAD: begin
                op_x = r_s;
                op_y = rd_s;
            end
            S_QLOAD: begin
                op_x = rd_s;
                op_y = r_t;
                op_u = r_t;
                op_v = rd_e;
            end
            default: begin
            end
        endcase
    end

    sist_cmp_unit u_cmp (
        .i_x   (op_x),
        .i_y   (op_y),
        .i_u   (op_u),
        .i_v   (op_v),
        .i_tol (r_tol),
        .o_res (cmp)
    );

    // A candidate joins the last entry when it starts at or before its end,
    // or after it by no more than the tolerance.
    assign joins = cmp.a_lt || cmp.a_eq || cmp.a_gap_ok;

    always_comb begin
        n_state     = r_state;
        n_bank      = r_bank;
        n_count     = r_count;
        n_i         = r_i;
        n_n         = r_n;
        n_have_last = r_have_last;
        n_placed    = r_placed;
        n_last_s    = r_last_s;
        n_last_e    = r_last_e;
        n_c_s       = r_c_s;
        n_c_e       = r_c_e;
        n_s         = r_s;
        n_e         = r_e;
        n_t         = r_t;
        n_status    = r_status;
        n_contained = r_contained;
        n_cidx      = r_cidx;
        n_cend      = r_cend;
        n_has_next  = r_has_next;
        n_nstart    = r_nstart;
        n_out       = r_out;
        n_out_valid = r_out_valid && !out_accept;
        wr_en       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_s         = i_in_item.start_time;
                    n_e         = i_in_item.end_time;
                    n_t         = i_in_item.query_time;
                    n_i         = '0;
                    n_n         = '0;
                    n_have_last = 1'b0;
                    n_placed    = 1'b0;
                    n_status    = ST_OK;
                    n_contained = 1'b0;
                    n_cidx      = '0;
                    n_cend      = '0;
                    n_has_next  = 1'b0;
                    n_nstart    = '0;
                    if (i_in_item.mode == MODE_QUERY) begin
                        n_state = S_QFETCH;
                    end else if (cmp.a_lt) begin
                        n_status = ST_BADARG;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                if (r_i == r_count) begin
                    if (!r_placed) begin
                        n_c_s    = r_s;
                        n_c_e    = r_e;
                        n_placed = 1'b1;
                        n_state  = S_MERGE;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                // The new interval goes in front of the first larger start;
                // that entry is then read again on the next pass.
                if (!r_placed && cmp.a_lt) begin
                    n_c_s    = r_s;
                    n_c_e    = r_e;
                    n_placed = 1'b1;
                end else begin
                    n_c_s = rd_s;
                    n_c_e = rd_e;
                    n_i   = r_i + CW'(1);
                end
                n_state = S_MERGE;
            end
            S_MERGE: begin
                if (r_have_last && joins) begin
                    if (cmp.b_lt) begin
                        n_last_e = r_c_e;
                    end
                end else begin
                    wr_en       = r_have_last && (r_n <= NW'(MAX_INTERVALS));
                    n_last_s    = r_c_s;
                    n_last_e    = r_c_e;
                    n_have_last = 1'b1;
                    if (r_n <= NW'(MAX_INTERVALS)) begin
                        n_n = r_n + NW'(1);
                    end
                end
                n_state = S_FETCH;
            end
            S_FLUSH: begin
                if (r_n > NW'(MAX_INTERVALS)) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_bank  = !r_bank;
                    n_count = CW'(r_n);
                end
                n_state = S_DONE;
            end
            S_QFETCH: begin
                if (r_i == r_count) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_QLOAD;
                end
            end
            S_QLOAD: begin
                // The last containing entry wins; the first start at or
                // after the time is the next start.
                if ((cmp.a_lt || cmp.a_eq) && cmp.b_lt) begin
                    n_contained = 1'b1;
                    n_cidx      = r_i[IW-1:0];
                    n_cend      = rd_e;
                end
                if (!r_has_next && !cmp.a_lt) begin
                    n_has_next = 1'b1;
                    n_nstart   = rd_s;
                end
                n_i     = r_i + CW'(1);
                n_state = S_QFETCH;
            end
            S_DONE: begin
                if (can_load) begin
                    n_out.status           = r_status;
                    n_out.contained        = r_contained;
                    n_out.containing_index = 4'(r_cidx);
                    n_out.current_end      = r_cend;
                    n_out.has_next         = r_has_next;
                    n_out.next_start       = r_nstart;
                    n_out.interval_count   = 5'(r_count);
                    n_out_valid            = 1'b1;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bank      <= 1'b0;
            r_count     <= '0;
            r_i         <= '0;
            r_n         <= '0;
            r_have_last <= 1'b0;
            r_placed    <= 1'b0;
            r_tol       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bank      <= n_bank;
            r_count     <= n_count;
            r_i         <= n_i;
            r_n         <= n_n;
            r_have_last <= n_have_last;
            r_placed    <= n_placed;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_tol <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_s    <= n_last_s;
        r_last_e    <= n_last_e;
        r_c_s       <= n_c_s;
        r_c_e       <= n_c_e;
        r_s         <= n_s;
        r_e         <= n_e;
        r_t         <= n_t;
        r_status    <= n_status;
        r_contained <= n_contained;
        r_cidx      <= n_cidx;
        r_cend      <= n_cend;
        r_has_next  <= n_has_next;
        r_nstart    <= n_nstart;
        r_out       <= n_out;
    end

    // The stored count never exceeds the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_INTERVALS))
        else $error("interval count beyond table depth");

    // Every table read during a walk lies below the stored count.
    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD || r_state == S_QLOAD) |-> (r_i < r_count))
        else $error("table read beyond stored entries");

    // The merged table never claims more than one entry past the depth.
    a_push_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NW'(MAX_INTERVALS + 1))
        else $error("merge count overflow");

    // An accepted item always puts the sequencer to work.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != S_IDLE))
        else $error("accepted item left the sequencer idle");

endmodule

[tb/tb_top.sv]
// Testbench of the sorted interval set table: random and directed items checked against a predictor.
`timescale 1ns / 100ps

module tb_top
    import sist_pkg::*;
();

    // Table depth of the block under test, also used by the predictor.
    localparam int MAX_SPANS = 16;
    // Hard limit on the run; the slowest correct run is several times shorter.
    localparam int TIMEOUT_NS = 5_000_000;
    // Longest time the block needs to finish one item.
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_ITEMS = 100;
    localparam int MARK_DEPTH = 48;

    logic                i_clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    t_in_item            in_item = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_out_item           out_item;
    logic                cfg_we = 1'b0;
    logic [TOL_BITS-1:0] cfg_data = '0;

    sorted_interval_set_table #(
        .MAX_INTERVALS(MAX_SPANS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: a private copy of the interval table and the tolerance.
    // ------------------------------------------------------------------
    logic [TIME_BITS-1:0] tab_start [MAX_SPANS];
    logic [TIME_BITS-1:0] tab_end   [MAX_SPANS];
    int                   tab_count = 0;
    logic [TOL_BITS-1:0]  tab_tolerance = '0;

    // Scratch table that an add is built in; one slot more than the table
    // so that an overflowing add can be detected before it is committed.
    logic [TIME_BITS-1:0] merged_start [MAX_SPANS+1];
    logic [TIME_BITS-1:0] merged_end   [MAX_SPANS+1];
    int                   merged_count;

    // Appends one interval to the scratch table, folding it into the last
    // entry when it starts inside that entry or within the tolerance gap.
    function automatic void merge_append(input logic [TIME_BITS-1:0] lo,
                                         input logic [TIME_BITS-1:0] hi);
        logic joins;
        joins = 1'b0;
        if (merged_count > 0) begin
            joins = (lo <= merged_end[merged_count-1]) ||
                    ((lo - merged_end[merged_count-1]) <= {16'b0, tab_tolerance});
        end
        if (joins) begin
            if (hi > merged_end[merged_count-1]) begin
                merged_end[merged_count-1] = hi;
            end
        end else if (merged_count < MAX_SPANS + 1) begin
            merged_start[merged_count] = lo;
            merged_end[merged_count]   = hi;
            merged_count++;
        end
    endfunction

    // Applies one accepted item to the predicted table and returns the
    // result item the block has to give for it.
    function automatic t_out_item predict_table_answer(input t_in_item it);
        t_out_item ans;
        logic      placed;
        ans = '0;
        if (it.mode == MODE_ADD) begin
            if (it.end_time < it.start_time) begin
                ans.status = ST_BADARG;
            end else begin
                // Rebuild the whole table in start order with the new
                // interval slotted in ahead of the first larger start.
                merged_count = 0;
                placed = 1'b0;
                for (int i = 0; i < tab_count; i++) begin
                    if (!placed && tab_start[i] > it.start_time) begin
                        merge_append(it.start_time, it.end_time);
                        placed = 1'b1;
                    end
                    merge_append(tab_start[i], tab_end[i]);
                end
                if (!placed) begin
                    merge_append(it.start_time, it.end_time);
                end
                if (merged_count > MAX_SPANS) begin
                    ans.status = ST_FULL;
                end else begin
                    for (int i = 0; i < merged_count; i++) begin
                        tab_start[i] = merged_start[i];
                        tab_end[i]   = merged_end[i];
                    end
                    tab_count = merged_count;
                    ans.status = ST_OK;
                end
            end
        end else begin
            // Half-open lookup; the next start is the first one at or after
            // the time, which is the lowest such start as the table is sorted.
            ans.status = ST_OK;
            for (int i = 0; i < tab_count; i++) begin
                if (tab_start[i] <= it.query_time && it.query_time < tab_end[i]) begin
                    ans.contained        = 1'b1;
                    ans.containing_index = i[3:0];
                    ans.current_end      = tab_end[i];
                end
                if (!ans.has_next && tab_start[i] >= it.query_time) begin
                    ans.has_next   = 1'b1;
                    ans.next_start = tab_start[i];
                end
            end
        end
        ans.interval_count = tab_count[4:0];
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Shared state of the stimulus, driver and monitor.
    // ------------------------------------------------------------------
    t_in_item  items_to_send[$];
    t_out_item answers_due[$];
    int        mismatches = 0;
    int        answers_seen = 0;
    bit        calm_tail = 1'b0;

    // Idle pattern used by both sides: mostly short random bursts, broken
    // up by stretches where the side never idles, and none at the tail.
    function automatic int roll_idle(inout int quiet);
        if (calm_tail) begin
            return 0;
        end
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet = $urandom_range(8, 40);
            return 0;
        end
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(1, 6);
        end
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued items, predicts each one as it is accepted.
    // The payload is held stable for as long as the block stalls it.
    // ------------------------------------------------------------------
    int send_gap = 0;
    int send_quiet = 0;

    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                answers_due.insert(answers_due.size(), predict_table_answer(in_item));
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (items_to_send.size() > 0) begin
                    in_item  <= items_to_send.pop_front();
                    in_valid <= 1'b1;
                    send_gap = roll_idle(send_quiet);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random stall bursts, and every accepted result is compared
    // field by field with the oldest prediction.
    // ------------------------------------------------------------------
    int stall_left = 0;
    int recv_quiet = 0;

    function automatic string describe_answer(input t_out_item r);
        return $sformatf("status=%0d contained=%0d index=%0d end=%h has_next=%0d next=%h count=%0d",
                         r.status, r.contained, r.containing_index, r.current_end,
                         r.has_next, r.next_start, r.interval_count);
    endfunction

    task automatic check_answer(input t_out_item got);
        t_out_item want;
        answers_seen++;
        if (answers_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Result %0d arrived with none outstanding: %s",
                         answers_seen, describe_answer(got));
            end
        end else begin
            want = answers_due.pop_front();
            if (got.status !== want.status || got.contained !== want.contained ||
                got.containing_index !== want.containing_index ||
                got.current_end !== want.current_end || got.has_next !== want.has_next ||
                got.next_start !== want.next_start ||
                got.interval_count !== want.interval_count) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch on result %0d", answers_seen);
                    $display("  expected: %s", describe_answer(want));
                    $display("  actual:   %s", describe_answer(got));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                check_answer(out_item);
            end
            if (stall_left == 0) begin
                stall_left = roll_idle(recv_quiet);
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation.
    // ------------------------------------------------------------------
    // Recent interval edges; queries aimed at them hit the boundaries.
    logic [TIME_BITS-1:0] edge_marks[$];
    logic [TIME_BITS-1:0] win_base;
    logic [TIME_BITS-1:0] win_span;

    task automatic queue_add(input logic [TIME_BITS-1:0] lo, input logic [TIME_BITS-1:0] hi);
        t_in_item it;
        it.mode       = MODE_ADD;
        it.start_time = lo;
        it.end_time   = hi;
        it.query_time = $urandom;
        items_to_send.insert(items_to_send.size(), it);
        edge_marks.insert(edge_marks.size(), lo);
        edge_marks.insert(edge_marks.size(), hi);
        while (edge_marks.size() > MARK_DEPTH) begin
            void'(edge_marks.pop_front());
        end
    endtask

    task automatic queue_query(input logic [TIME_BITS-1:0] t);
        t_in_item it;
        it.mode       = MODE_QUERY;
        it.start_time = $urandom;
        it.end_time   = $urandom;
        it.query_time = t;
        items_to_send.insert(items_to_send.size(), it);
    endtask

    // A time in the current window, now and then anywhere in the range.
    function automatic logic [TIME_BITS-1:0] pick_time();
        if ($urandom_range(0, 15) == 0) begin
            return $urandom;
        end
        return win_base + $urandom_range(0, win_span);
    endfunction

    function automatic logic [TIME_BITS-1:0] clip_end(input logic [TIME_BITS-1:0] lo,
                                                      input logic [TIME_BITS-1:0] len);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, lo} + {1'b0, len};
        return sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
    endfunction

    task automatic queue_random_item();
        logic [TIME_BITS-1:0] lo;
        logic [TIME_BITS-1:0] hi;
        logic [TIME_BITS-1:0] t;
        int                   pick;
        pick = $urandom_range(0, 19);
        if ($urandom_range(0, 1) == 1) begin
            // Queries mostly land on or next to a known edge.
            if (pick < 13 && edge_marks.size() > 0) begin
                t = edge_marks[$urandom_range(0, edge_marks.size() - 1)];
                t = t + $urandom_range(0, 2) - 1;
            end else begin
                t = pick_time();
            end
            queue_query(t);
        end else begin
            lo = pick_time();
            if (pick < 10) begin
                hi = clip_end(lo, $urandom_range(0, win_span >> 3));
            end else if (pick < 13) begin
                // Start right at the merge limit after a known edge.
                if (edge_marks.size() > 0) begin
                    lo = edge_marks[$urandom_range(0, edge_marks.size() - 1)];
                    lo = lo + {16'b0, tab_tolerance} + $urandom_range(0, 1);
                end
                hi = clip_end(lo, $urandom_range(0, win_span >> 4));
            end else if (pick < 15) begin
                hi = clip_end(lo, $urandom_range(0, win_span));
            end else if (pick < 16) begin
                hi = lo;
            end else if (pick < 18) begin
                // End before start.
                if (lo == '0) begin
                    lo = 1;
                end
                hi = lo - $urandom_range(1, (lo > 1000) ? 1000 : lo);
            end else begin
                lo = $urandom;
                hi = $urandom;
            end
            queue_add(lo, hi);
        end
    endtask

    // Waits until everything queued has been sent and answered.
    task automatic wait_for_drain();
        while (items_to_send.size() != 0 || in_valid || answers_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_tolerance(input logic [TOL_BITS-1:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        tab_tolerance = value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    logic [TOL_BITS-1:0]  tol_plan  [PHASE_COUNT] = '{16'hFFFF, 16'd0, 16'd1, 16'd0, 16'd64,
                                                      16'hFFFF};
    logic [TIME_BITS-1:0] span_plan [PHASE_COUNT] = '{32'h0010_0000, 32'h0000_4000,
                                                      32'h0400_0000, 32'h0000_1000,
                                                      32'h0001_0000, 32'h00FF_FFFF};

    initial begin
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, with the tolerance at its reset value of zero.
        queue_query(32'h0);                        // empty table
        queue_add(32'd5, 32'd3);                   // end before start
        queue_add(32'h0, 32'h0);                   // zero-length at the bottom
        queue_query(32'h0);                        // holds no time, but is a next start
        queue_add(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // zero-length at the top
        queue_add(32'd100, 32'd200);
        queue_add(32'd200, 32'd300);               // touching, merges
        queue_query(32'd200);
        queue_query(32'd300);                      // end is outside the interval
        queue_query(32'hFFFF_FFFF);
        // Fill the table to its depth; the last of these adds has no room.
        for (int k = 1; k <= 14; k++) begin
            queue_add(k * 1000, k * 1000 + 10);
        end
        queue_add(32'h0, 32'hFFFF_FFFF);           // swallows the whole table
        wait_for_drain();

        // Random phases, each at its own tolerance and time window.
        tol_plan[3] = TOL_BITS'($urandom_range(2, 16'hFFFE));
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_tolerance(tol_plan[p]);
            @(negedge i_clk);
            win_span = span_plan[p];
            win_base = $urandom_range(0, 32'hFFFF_FFFF - win_span);
            if (p == PHASE_COUNT - 1) begin
                calm_tail = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                queue_random_item();
            end
            // The sender holds off here until every result is back.
            wait_for_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[sorted_interval_set_table.f]
hdl/sist_pkg.sv
hdl/sist_ram.sv
hdl/sist_cmp_unit.sv
hdl/sorted_interval_set_table.sv
tb/tb_top.sv
